[hdl/lad_pkg.sv]
// ----------------------------------------------------------------------------
// lad_pkg
// Shared widths, codes and payload types of the layered atmosphere block.
// ----------------------------------------------------------------------------
package lad_pkg;

    // value word and full product widths
    localparam int VW         = 48;
    localparam int PW         = 2 * VW;

    // internal fraction bits of exp and ln
    localparam int IP         = 30;

    // multiplier slice width
    localparam int MUL_STEP   = 16;

    // defaults of the top level parameters
    localparam int LAYERS_DEF = 5;
    localparam int FRAC_DEF   = 16;

    // ln(2) in Q0.30
    localparam logic [IP-1:0] LN2_Q30 = 30'd744261118;

    // series lengths
    localparam int EXP_TERMS  = 13;
    localparam int LN_TERMS   = 10;

    // operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_DEPTH  = 2'd1;
    localparam logic [1:0] OP_HEIGHT = 2'd2;
    localparam logic [1:0] OP_DERIVE = 2'd3;

    // coefficient select codes
    localparam logic [1:0] SEL_HEIGHT = 2'd0;
    localparam logic [1:0] SEL_OFFSET = 2'd1;
    localparam logic [1:0] SEL_SCALE  = 2'd2;
    localparam logic [1:0] SEL_LENGTH = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_DOMAIN = 2'd2;

    typedef struct packed {
        logic [1:0]             op;
        logic [2:0]             layer;
        logic [1:0]             coef_sel;
        logic signed [VW-1:0]   coef_value;
        logic signed [VW-1:0]   query_value;
    } t_in;

    typedef struct packed {
        logic signed [VW-1:0]   result_value;
        logic [1:0]             status;
    } t_out;

endpackage

[hdl/lad_mul.sv]
// ----------------------------------------------------------------------------
// lad_mul
// Unsigned multi-cycle multiplier, one operand slice per cycle.
// ----------------------------------------------------------------------------
module lad_mul
    import lad_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [VW-1:0]   i_a,
    input  logic [VW-1:0]   i_b,
    output logic            o_done,
    output logic [PW-1:0]   o_prod
);

    localparam int CHUNKS = VW / MUL_STEP;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    logic [VW-1:0]          r_a;
    logic [VW-1:0]          r_b;
    logic [PW-1:0]          r_acc;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [VW+MUL_STEP-1:0] pp;
    logic [PW-1:0]          pp_sh;

    // partial product of one slice, placed at its weight
    assign pp    = r_a * r_b[MUL_STEP-1:0];
    assign pp_sh = PW'(pp) << (r_cnt * MUL_STEP);

    // slice sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + pp_sh;
                r_b   <= r_b >> MUL_STEP;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(CHUNKS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[hdl/lad_div.sv]
// ----------------------------------------------------------------------------
// lad_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module lad_div
    import lad_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [PW-1:0]   i_num,
    input  logic [VW-1:0]   i_den,
    output logic            o_done,
    output logic [VW-1:0]   o_quo,
    output logic [VW-1:0]   o_rem
);

    localparam int NW = $clog2(VW);

    logic [VW-1:0]  r_rem;
    logic [VW-1:0]  r_lo;
    logic [VW-1:0]  r_den;
    logic [NW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [VW:0]    trial;
    logic [VW:0]    diff;
    logic           ge;

    // one trial subtract per cycle
    assign trial = {r_rem, r_lo[VW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    // the upper dividend half must be below the divisor at start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num[PW-1:VW];
                r_lo   <= i_num[VW-1:0];
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
                r_lo  <= {r_lo[VW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(VW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_lo;
    assign o_rem  = r_rem;

endmodule

[hdl/layered_atmosphere_depth_height.sv]
// ----------------------------------------------------------------------------
// layered_atmosphere_depth_height
// Layered atmosphere height/depth converter: coefficient table, layer scan,
// and a sequencer driving one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// A lower-layer query runs exp (14 divides) or ln (normalize steps and 11 divides)
// on the shared divider; a top-layer query needs neither series.
// Derive runs the depth computation once per layer.
// One item in flight; the next is taken once the result is in the output register.
// Reset (synchronous, active low) clears all tables to zero and idles the block.
module layered_atmosphere_depth_height
    import lad_pkg::*;
#(
    parameter int LAYERS    = LAYERS_DEF,
    parameter int FRAC_BITS = FRAC_DEF
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in     i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out_data
);

    localparam int IW = $clog2(LAYERS);
    localparam int SH = IP - FRAC_BITS;
    localparam int CW = $clog2(VW);

    localparam logic signed [VW-1:0] ONE_V  = VW'(1) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] MAX_V  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] MIN_V  = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0]        MAX_U  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW:0]   EXP_HI = (VW+1)'(40) <<< FRAC_BITS;
    localparam logic signed [VW:0]   EXP_LO = -((VW+1)'(64) <<< FRAC_BITS);
    localparam logic [VW-1:0]        IONE   = VW'(1) << IP;
    localparam logic [IW-1:0]        TOP    = IW'(LAYERS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DV_LOAD, S_SCAN, S_LO, S_LO2, S_LO3, S_LO4, S_TOP2, S_CMPL, S_OUT,
        S_MD_MULW, S_MD_DIVW,
        S_EX_KW, S_EX_MUL, S_EX_MULW, S_EX_DIVW, S_EX_FIN,
        S_LN_NORM, S_LN_SW, S_LN_S2W, S_LN_DIV, S_LN_DIVW, S_LN_PWW, S_LN_FIN
    } t_state;

    // saturate a 49-bit sum to the value range
    function automatic logic signed [VW-1:0] sat(input logic signed [VW:0] v);
        if (v[VW] != v[VW-1]) begin
            return v[VW] ? MIN_V : MAX_V;
        end
        return v[VW-1:0];
    endfunction

    // magnitude, most negative value maps to 2^(VW-1)
    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
        logic [VW-1:0] u;
        u = v;
        return v[VW-1] ? (~u + 1'b1) : u;
    endfunction

    // state
    t_state                 r_state;
    t_state                 r_ret;
    logic signed [VW-1:0]   r_bh [LAYERS];
    logic signed [VW-1:0]   r_ca [LAYERS];
    logic signed [VW-1:0]   r_cb [LAYERS];
    logic signed [VW-1:0]   r_cc [LAYERS];
    logic signed [VW-1:0]   r_bd [LAYERS];

    logic [1:0]             r_op;
    logic signed [VW-1:0]   r_x;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          r_didx;
    logic                   r_prev;
    logic                   r_top;
    logic signed [VW-1:0]   r_res;
    logic [1:0]             r_st;
    logic                   r_ov;
    t_out                   r_out;

    // product-quotient call
    logic [VW-1:0]          r_md_den;
    logic                   r_md_dz;
    logic                   r_neg;
    logic signed [VW-1:0]   r_mdres;
    logic                   r_mderr;
    logic signed [VW-1:0]   r_fres;

    // exp series
    logic                   r_twneg;
    logic signed [15:0]     r_k;
    logic [VW-1:0]          r_r;
    logic [VW-1:0]          r_term;
    logic [VW-1:0]          r_sum;
    logic [3:0]             r_n;

    // ln series
    logic [VW-1:0]          r_lu;
    logic [CW-1:0]          r_lcnt;
    logic [VW-1:0]          r_pw;
    logic [VW-1:0]          r_s2;
    logic [VW-1:0]          r_lsum;
    logic [3:0]             r_lk;

    // shared unit requests
    logic                   r_mul_go;
    logic [VW-1:0]          r_mul_a;
    logic [VW-1:0]          r_mul_b;
    logic                   r_div_go;
    logic [PW-1:0]          r_div_num;
    logic [VW-1:0]          r_div_den;

    logic                   mul_done;
    logic [PW-1:0]          mul_prod;
    logic                   div_done;
    logic [VW-1:0]          div_quo;
    logic [VW-1:0]          div_rem;

    logic signed [VW-1:0]   rd_bh, rd_a, rd_b, rd_c, rd_bd;
    logic                   cmp;
    logic signed [VW-1:0]   x_sub_a, a_sub_x;
    logic signed [VW-1:0]   c_p, c_q, c_d;
    logic signed [VW:0]     et;
    logic signed [VW:0]     tw;
    logic [VW-1:0]          tw_mag;
    logic signed [15:0]     ex_s;
    logic signed [15:0]     ex_ns;
    logic [VW-1:0]          ex_res;
    logic [IP:0]            ln_y;
    logic [IP:0]            ln_y1;
    logic signed [15:0]     ln_m;
    logic signed [VW:0]     ln_tot;
    logic [15:0]            qm;
    logic                   layer_ok;

    lad_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    lad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // table read, one address
    assign rd_bh = r_bh[r_idx];
    assign rd_a  = r_ca[r_idx];
    assign rd_b  = r_cb[r_idx];
    assign rd_c  = r_cc[r_idx];
    assign rd_bd = r_bd[r_idx];

    // boundary test of the scan
    assign cmp = (r_op == OP_HEIGHT) ? (rd_bd >= r_x) : (rd_bh <= r_x);

    assign x_sub_a = sat({r_x[VW-1], r_x} - {rd_a[VW-1], rd_a});
    assign a_sub_x = sat({rd_a[VW-1], rd_a} - {r_x[VW-1], r_x});

    assign layer_ok = {1'b0, i_in_data.layer} < 4'(LAYERS);

    // operands of the product-quotient call
    always_comb begin
        c_p = rd_c;
        c_q = r_fres;
        c_d = ONE_V;
        if (r_state == S_LO3) begin
            if (r_op != OP_HEIGHT) begin
                c_p = rd_b;
            end
        end else begin
            case ({r_op == OP_HEIGHT, r_top})
                2'b00: begin
                    c_p = r_x;
                    c_q = ONE_V;
                    c_d = rd_c;
                end
                2'b01: begin
                    c_p = rd_b;
                    c_q = r_x;
                    c_d = rd_c;
                end
                2'b10: begin
                    c_p = rd_b;
                    c_q = ONE_V;
                    c_d = x_sub_a;
                end
                default: begin
                    c_p = rd_c;
                    c_q = a_sub_x;
                    c_d = rd_b;
                end
            endcase
        end
    end

    // exp argument and range reduction input
    assign et     = -{r_mdres[VW-1], r_mdres};
    assign tw     = et <<< SH;
    assign tw_mag = tw[VW] ? VW'(-tw) : tw[VW-1:0];
    assign qm     = div_quo[15:0];

    // exp final scaling by 2^k
    always_comb begin
        ex_s   = r_k - 16'(SH);
        ex_ns  = -ex_s;
        ex_res = '0;
        if (!ex_s[15]) begin
            if (ex_s >= 16'(VW - 1) || r_sum > (MAX_U >> ex_s)) begin
                ex_res = MAX_U;
            end else begin
                ex_res = r_sum << ex_s;
            end
        end else if (ex_ns < 16'sd63) begin
            ex_res = r_sum >> ex_ns;
        end
    end

    // ln mantissa and final sum
    assign ln_y   = r_lu[VW-2 -: IP+1];
    assign ln_y1  = ln_y - (IP+1)'(IONE);
    assign ln_m   = 16'(VW - 2 - FRAC_BITS) - 16'(r_lcnt);
    assign ln_tot = (VW+1)'(ln_m) * $signed({1'b0, LN2_Q30})
                  + $signed({1'b0, r_lsum[VW-2:0], 1'b0});

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            for (int i = 0; i < LAYERS; i++) begin
                r_bh[i] <= '0;
                r_ca[i] <= '0;
                r_cb[i] <= '0;
                r_cc[i] <= '0;
                r_bd[i] <= '0;
            end
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                // accept an item
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op  <= i_in_data.op;
                        r_x   <= i_in_data.query_value;
                        r_idx <= '0;
                        r_res <= '0;
                        r_st  <= ST_OK;
                        case (i_in_data.op)
                            OP_LOAD: begin
                                if (layer_ok) begin
                                    case (i_in_data.coef_sel)
                                        SEL_HEIGHT: r_bh[i_in_data.layer[IW-1:0]] <=
                                            i_in_data.coef_value;
                                        SEL_OFFSET: r_ca[i_in_data.layer[IW-1:0]] <=
                                            i_in_data.coef_value;
                                        SEL_SCALE:  r_cb[i_in_data.layer[IW-1:0]] <=
                                            i_in_data.coef_value;
                                        default:    r_cc[i_in_data.layer[IW-1:0]] <=
                                            i_in_data.coef_value;
                                    endcase
                                end
                                r_state <= S_OUT;
                            end
                            OP_DERIVE: begin
                                r_didx  <= '0;
                                r_state <= S_DV_LOAD;
                            end
                            default: begin
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end

                // derive: boundary height becomes the query
                S_DV_LOAD: begin
                    r_x     <= rd_bh;
                    r_idx   <= '0;
                    r_state <= S_SCAN;
                end

                // layer search, first match wins
                S_SCAN: begin
                    if (r_idx == '0) begin
                        r_prev <= cmp;
                        r_idx  <= r_idx + 1'b1;
                    end else if (r_prev && !cmp) begin
                        r_idx   <= r_idx - 1'b1;
                        r_top   <= 1'b0;
                        r_state <= S_LO;
                    end else if (r_idx == TOP) begin
                        if (cmp) begin
                            r_top   <= 1'b1;
                            r_state <= S_LO;
                        end else begin
                            r_res   <= -ONE_V;
                            r_st    <= ST_RANGE;
                            r_state <= S_CMPL;
                        end
                    end else begin
                        r_prev <= cmp;
                        r_idx  <= r_idx + 1'b1;
                    end
                end

                // first product-quotient call, or the later one
                S_LO, S_LO3: begin
                    r_mul_go <= 1'b1;
                    r_mul_a  <= mag(c_p);
                    r_mul_b  <= mag(c_q);
                    r_md_den <= mag(c_d);
                    r_md_dz  <= (c_d == '0);
                    r_neg    <= c_p[VW-1] ^ c_q[VW-1] ^ c_d[VW-1];
                    if (r_state == S_LO3) begin
                        r_ret <= S_LO4;
                    end else begin
                        r_ret <= r_top ? S_TOP2 : S_LO2;
                    end
                    r_state <= S_MD_MULW;
                end

                // lower layer: start exp or ln
                S_LO2: begin
                    if (r_op == OP_HEIGHT) begin
                        if (r_mderr || r_mdres <= 0) begin
                            r_res   <= '0;
                            r_st    <= ST_DOMAIN;
                            r_state <= S_CMPL;
                        end else begin
                            r_lu    <= r_mdres;
                            r_lcnt  <= '0;
                            r_state <= S_LN_NORM;
                        end
                    end else if (r_mderr) begin
                        r_res   <= '0;
                        r_st    <= ST_DOMAIN;
                        r_state <= S_CMPL;
                    end else if (et > EXP_HI) begin
                        r_fres  <= MAX_V;
                        r_state <= S_LO3;
                    end else if (et < EXP_LO) begin
                        r_fres  <= '0;
                        r_state <= S_LO3;
                    end else begin
                        r_twneg   <= tw[VW];
                        r_div_go  <= 1'b1;
                        r_div_num <= PW'(tw_mag);
                        r_div_den <= VW'(LN2_Q30);
                        r_state   <= S_EX_KW;
                    end
                end

                // lower layer result
                S_LO4: begin
                    if (r_op == OP_HEIGHT) begin
                        r_res <= r_mdres;
                    end else begin
                        r_res <= sat({rd_a[VW-1], rd_a} + {r_mdres[VW-1], r_mdres});
                    end
                    r_st    <= ST_OK;
                    r_state <= S_CMPL;
                end

                // top layer result
                S_TOP2: begin
                    if (r_mderr) begin
                        r_res <= '0;
                        r_st  <= ST_DOMAIN;
                    end else begin
                        r_st <= ST_OK;
                        if (r_op == OP_HEIGHT) begin
                            r_res <= r_mdres;
                        end else begin
                            r_res <= sat({rd_a[VW-1], rd_a} - {r_mdres[VW-1], r_mdres});
                        end
                    end
                    r_state <= S_CMPL;
                end

                // store a derived depth or hand over the result
                S_CMPL: begin
                    if (r_op == OP_DERIVE) begin
                        r_bd[r_didx] <= r_res;
                        if (r_didx == TOP) begin
                            r_res   <= '0;
                            r_st    <= ST_OK;
                            r_state <= S_OUT;
                        end else begin
                            r_didx  <= r_didx + 1'b1;
                            r_idx   <= r_didx + 1'b1;
                            r_state <= S_DV_LOAD;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end

                // output register load
                S_OUT: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov                <= 1'b1;
                        r_out.result_value  <= r_res;
                        r_out.status        <= r_st;
                        r_state             <= S_IDLE;
                    end
                end

                // product done: zero divisor, saturation or divide
                S_MD_MULW: begin
                    if (mul_done) begin
                        if (r_md_dz) begin
                            r_mderr <= 1'b1;
                            r_mdres <= '0;
                            r_state <= r_ret;
                        end else if (mul_prod[PW-1:VW-1] >= {1'b0, r_md_den}) begin
                            r_mderr <= 1'b0;
                            r_mdres <= r_neg ? MIN_V : MAX_V;
                            r_state <= r_ret;
                        end else begin
                            r_div_go  <= 1'b1;
                            r_div_num <= mul_prod;
                            r_div_den <= r_md_den;
                            r_state   <= S_MD_DIVW;
                        end
                    end
                end

                S_MD_DIVW: begin
                    if (div_done) begin
                        r_mderr <= 1'b0;
                        r_mdres <= r_neg ? -$signed(div_quo) : $signed(div_quo);
                        r_state <= r_ret;
                    end
                end

                // exp: floor split into k*ln2 + r
                S_EX_KW: begin
                    if (div_done) begin
                        if (!r_twneg) begin
                            r_k <= $signed(qm);
                            r_r <= VW'(div_rem[IP-1:0]);
                        end else if (div_rem == '0) begin
                            r_k <= -$signed(qm);
                            r_r <= '0;
                        end else begin
                            r_k <= -$signed(qm) - 16'sd1;
                            r_r <= VW'(LN2_Q30 - div_rem[IP-1:0]);
                        end
                        r_term  <= IONE;
                        r_sum   <= IONE;
                        r_n     <= 4'd1;
                        r_state <= S_EX_MUL;
                    end
                end

                // exp: term = (term * r >> IP) / n
                S_EX_MUL: begin
                    r_mul_go <= 1'b1;
                    r_mul_a  <= r_term;
                    r_mul_b  <= r_r;
                    r_state  <= S_EX_MULW;
                end

                S_EX_MULW: begin
                    if (mul_done) begin
                        r_div_go  <= 1'b1;
                        r_div_num <= mul_prod >> IP;
                        r_div_den <= VW'(r_n);
                        r_state   <= S_EX_DIVW;
                    end
                end

                S_EX_DIVW: begin
                    if (div_done) begin
                        r_term <= div_quo;
                        r_sum  <= r_sum + div_quo;
                        if (r_n == 4'(EXP_TERMS)) begin
                            r_state <= S_EX_FIN;
                        end else begin
                            r_n     <= r_n + 1'b1;
                            r_state <= S_EX_MUL;
                        end
                    end
                end

                S_EX_FIN: begin
                    r_fres  <= $signed(ex_res);
                    r_state <= S_LO3;
                end

                // ln: normalize one bit a cycle
                S_LN_NORM: begin
                    if (r_lu[VW-2]) begin
                        r_div_go  <= 1'b1;
                        r_div_num <= PW'(ln_y1) << IP;
                        r_div_den <= VW'(ln_y) + IONE;
                        r_state   <= S_LN_SW;
                    end else begin
                        r_lu   <= r_lu << 1;
                        r_lcnt <= r_lcnt + 1'b1;
                    end
                end

                // ln: s = (y-1)/(y+1), then s squared
                S_LN_SW: begin
                    if (div_done) begin
                        r_pw     <= div_quo;
                        r_mul_go <= 1'b1;
                        r_mul_a  <= div_quo;
                        r_mul_b  <= div_quo;
                        r_state  <= S_LN_S2W;
                    end
                end

                S_LN_S2W: begin
                    if (mul_done) begin
                        r_s2    <= VW'(mul_prod >> IP);
                        r_lk    <= '0;
                        r_lsum  <= '0;
                        r_state <= S_LN_DIV;
                    end
                end

                // ln: sum += pw / (2k+1)
                S_LN_DIV: begin
                    r_div_go  <= 1'b1;
                    r_div_num <= PW'(r_pw);
                    r_div_den <= VW'({r_lk, 1'b1});
                    r_state   <= S_LN_DIVW;
                end

                S_LN_DIVW: begin
                    if (div_done) begin
                        r_lsum <= r_lsum + div_quo;
                        if (r_lk == 4'(LN_TERMS - 1)) begin
                            r_state <= S_LN_FIN;
                        end else begin
                            r_mul_go <= 1'b1;
                            r_mul_a  <= r_pw;
                            r_mul_b  <= r_s2;
                            r_state  <= S_LN_PWW;
                        end
                    end
                end

                S_LN_PWW: begin
                    if (mul_done) begin
                        r_pw    <= VW'(mul_prod >> IP);
                        r_lk    <= r_lk + 1'b1;
                        r_state <= S_LN_DIV;
                    end
                end

                // ln: exponent part plus series, floor to value format
                S_LN_FIN: begin
                    r_fres  <= VW'(ln_tot >>> SH);
                    r_state <= S_LO3;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule
